// File: hdl/fit_policy_block_allocator_assert.svh
// assertion helpers for the block allocator
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FPBA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fit_policy_block_allocator: check failed");

// next-cycle implication
`define FPBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fit_policy_block_allocator: check failed");

`endif

// File: hdl/fpba_pkg.sv
package fpba_pkg;

    localparam int BLOCKS_DEF     = 16;
    localparam int SIZE_WIDTH_DEF = 16;

    // fixed field widths
    localparam int FUNC_W   = 1;
    localparam int INDEX_W  = 4;
    localparam int AMOUNT_W = 16;
    localparam int NUMBER_W = 16;
    localparam int BIU_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;

    localparam logic [BIU_W-1:0] BIU_RESET = 5'd16;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_NEXT  = 2'd1,
        POL_BEST  = 2'd2,
        POL_WORST = 2'd3
    } t_policy;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

// File: hdl/fpba_ram.sv
module fpba_ram #(
    parameter int WIDTH = fpba_pkg::SIZE_WIDTH_DEF,
    parameter int DEPTH = fpba_pkg::BLOCKS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/fit_policy_block_allocator.sv
// channel     | direction | handshake                  | payload
// ------------+-----------+----------------------------+-------------------------------------
// command     | in        | i_start & !o_busy          | i_func, i_block_index, i_amount
// result      | out       | o_done (one-cycle strobe)  | o_granted, o_chosen_block,
//             |           |                            | o_block_size, o_request_size,
//             |           |                            | o_space_left, o_request_number
// config      | in        | i_cfg_valid & o_cfg_ready  | i_cfg_index, i_cfg_data
//
// a load leaves o_busy low; it gives no result
// an allocate holds o_busy while it scans blocks_in_use blocks; first or next fit
// stops early: the remaining-space memory is read one block per cycle into one comparator
// the result strobe is high in the first cycle with o_busy low again
// synchronous active-low reset sets first fit, 16 blocks in use and zero next pointer
// and request count; block sizes are undefined until loaded
// results cannot be stalled; config writes are always taken
module fit_policy_block_allocator #(
    parameter int BLOCKS     = fpba_pkg::BLOCKS_DEF,
    parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [fpba_pkg::FUNC_W-1:0]         i_func,
    input  logic [fpba_pkg::INDEX_W-1:0]        i_block_index,
    input  logic [fpba_pkg::AMOUNT_W-1:0]       i_amount,
    output logic                                o_done,
    output logic                                o_granted,
    output logic [fpba_pkg::INDEX_W-1:0]        o_chosen_block,
    output logic [fpba_pkg::AMOUNT_W-1:0]       o_block_size,
    output logic [fpba_pkg::AMOUNT_W-1:0]       o_request_size,
    output logic [fpba_pkg::AMOUNT_W-1:0]       o_space_left,
    output logic [fpba_pkg::NUMBER_W-1:0]       o_request_number,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IW = $clog2(BLOCKS);
    localparam int UW = $clog2(BLOCKS + 1);
    localparam int SW = SIZE_WIDTH;

    // control
    fpba_pkg::t_state              r_state, n_state;
    fpba_pkg::t_policy             r_policy, n_policy;
    logic [fpba_pkg::BIU_W-1:0]    r_biu, n_biu;
    logic [IW-1:0]                 r_np, n_np;
    logic [fpba_pkg::NUMBER_W-1:0] r_cnt, n_cnt;
    logic                          r_issue, n_issue;
    logic                          r_vld, n_vld;
    logic                          r_found, n_found;
    logic                          r_done, n_done;

    // payload
    logic [UW-1:0]                 r_units, n_units;
    logic [SW-1:0]                 r_req, n_req;
    logic [IW-1:0]                 r_addr, n_addr;
    logic                          r_down, n_down;
    logic [IW-1:0]                 r_ev_idx, n_ev_idx;
    logic [IW-1:0]                 r_pick, n_pick;
    logic [SW-1:0]                 r_best, n_best;
    logic                          r_granted, n_granted;
    logic [fpba_pkg::INDEX_W-1:0]  r_chosen, n_chosen;
    logic [fpba_pkg::AMOUNT_W-1:0] r_bsize, n_bsize;
    logic [fpba_pkg::AMOUNT_W-1:0] r_reqsz, n_reqsz;
    logic [fpba_pkg::AMOUNT_W-1:0] r_left, n_left;

    logic          w_accept;
    logic          w_load;
    logic [SW-1:0] w_amount;
    logic [UW-1:0] w_units;
    logic [UW-1:0] w_addr_inc;
    logic [UW-1:0] w_np_inc;
    logic [SW-1:0] w_rem_q;
    logic [SW-1:0] w_orig_q;
    logic [SW-1:0] w_new_left;
    logic          w_fit;
    logic          w_take;
    logic          w_rem_we;
    logic [IW-1:0] w_rem_waddr;
    logic [SW-1:0] w_rem_wdata;

    assign w_accept   = i_start && (r_state == fpba_pkg::S_IDLE);
    assign w_amount   = SW'(i_amount);
    assign w_load     = w_accept && (i_func == fpba_pkg::FUNC_LOAD)
                        && (32'(i_block_index) < BLOCKS);
    assign w_units    = (32'(r_biu) > BLOCKS) ? UW'(BLOCKS) : UW'(r_biu);
    assign w_addr_inc = UW'(r_addr) + UW'(1);
    assign w_np_inc   = UW'(r_pick) + UW'(1);
    assign w_new_left = r_best - r_req;

    // shared compare unit: fit test and best/worst ranking
    always_comb begin
        w_fit  = (w_rem_q >= r_req);
        w_take = 1'b0;
        if (r_vld && w_fit) begin
            case (r_policy)
                fpba_pkg::POL_BEST:  w_take = !r_found || (w_rem_q < r_best);
                fpba_pkg::POL_WORST: w_take = !r_found || (w_rem_q > r_best);
                default:             w_take = 1'b1;
            endcase
        end
    end

    assign w_rem_we    = w_load || ((r_state == fpba_pkg::S_DONE) && r_found);
    assign w_rem_waddr = w_load ? IW'(i_block_index) : r_pick;
    assign w_rem_wdata = w_load ? w_amount : w_new_left;

    fpba_ram #(
        .WIDTH (SW),
        .DEPTH (BLOCKS)
    ) u_remaining (
        .i_clk   (i_clk),
        .i_we    (w_rem_we),
        .i_waddr (w_rem_waddr),
        .i_wdata (w_rem_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rem_q)
    );

    fpba_ram #(
        .WIDTH (SW),
        .DEPTH (BLOCKS)
    ) u_original (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (IW'(i_block_index)),
        .i_wdata (w_amount),
        .i_raddr (r_pick),
        .o_rdata (w_orig_q)
    );

    always_comb begin
        n_state   = r_state;
        n_policy  = r_policy;
        n_biu     = r_biu;
        n_np      = r_np;
        n_cnt     = r_cnt;
        n_issue   = r_issue;
        n_vld     = 1'b0;
        n_found   = r_found;
        n_done    = 1'b0;
        n_units   = r_units;
        n_req     = r_req;
        n_addr    = r_addr;
        n_down    = r_down;
        n_ev_idx  = r_addr;
        n_pick    = r_pick;
        n_best    = r_best;
        n_granted = r_granted;
        n_chosen  = r_chosen;
        n_bsize   = r_bsize;
        n_reqsz   = r_reqsz;
        n_left    = r_left;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fpba_pkg::CFG_FIT_POLICY:    n_policy = fpba_pkg::t_policy'(i_cfg_data[1:0]);
                fpba_pkg::CFG_BLOCKS_IN_USE: n_biu    = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            fpba_pkg::S_IDLE: begin
                if (w_load) begin
                    n_np = '0;
                end
                if (w_accept && (i_func == fpba_pkg::FUNC_ALLOC)) begin
                    n_state = fpba_pkg::S_SCAN;
                    n_cnt   = r_cnt + fpba_pkg::NUMBER_W'(1);
                    n_units = w_units;
                    n_req   = w_amount;
                    n_found = 1'b0;
                    n_issue = (w_units != '0);
                    n_addr  = '0;
                    n_down  = 1'b0;
                    if (r_policy == fpba_pkg::POL_NEXT) begin
                        if (UW'(r_np) < w_units) begin
                            n_addr = r_np;
                        end else begin
                            // stale pointer: only the downward pass from the top
                            n_addr = IW'(w_units - UW'(1));
                            n_down = 1'b1;
                        end
                    end
                end
            end
            fpba_pkg::S_SCAN: begin
                n_vld = r_issue;
                if (r_issue) begin
                    if (!r_down) begin
                        if (w_addr_inc < r_units) begin
                            n_addr = IW'(w_addr_inc);
                        end else if ((r_policy == fpba_pkg::POL_NEXT) && (r_np != '0)) begin
                            n_addr = r_np - IW'(1);
                            n_down = 1'b1;
                        end else begin
                            n_issue = 1'b0;
                        end
                    end else if (r_addr != '0) begin
                        n_addr = r_addr - IW'(1);
                    end else begin
                        n_issue = 1'b0;
                    end
                end
                if (w_take) begin
                    n_found = 1'b1;
                    n_pick  = r_ev_idx;
                    n_best  = w_rem_q;
                end
                if (w_take && (r_policy == fpba_pkg::POL_FIRST
                               || r_policy == fpba_pkg::POL_NEXT)) begin
                    n_issue = 1'b0;
                    n_vld   = 1'b0;
                    n_state = fpba_pkg::S_READ;
                end else if (!r_issue && !r_vld) begin
                    n_state = r_found ? fpba_pkg::S_READ : fpba_pkg::S_DONE;
                end
            end
            fpba_pkg::S_READ: begin
                n_state = fpba_pkg::S_DONE;
            end
            fpba_pkg::S_DONE: begin
                n_state   = fpba_pkg::S_IDLE;
                n_done    = 1'b1;
                n_granted = r_found;
                n_reqsz   = fpba_pkg::AMOUNT_W'(r_req);
                if (r_found) begin
                    n_chosen = fpba_pkg::INDEX_W'(r_pick);
                    n_bsize  = fpba_pkg::AMOUNT_W'(w_orig_q);
                    n_left   = fpba_pkg::AMOUNT_W'(w_new_left);
                    if (r_policy == fpba_pkg::POL_NEXT) begin
                        n_np = (w_np_inc < r_units) ? IW'(w_np_inc) : '0;
                    end
                end else begin
                    n_chosen = '0;
                    n_bsize  = '0;
                    n_left   = '0;
                end
            end
            default: n_state = fpba_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fpba_pkg::S_IDLE;
            r_policy <= fpba_pkg::POL_FIRST;
            r_biu    <= fpba_pkg::BIU_RESET;
            r_np     <= '0;
            r_cnt    <= '0;
            r_issue  <= 1'b0;
            r_vld    <= 1'b0;
            r_found  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_policy <= n_policy;
            r_biu    <= n_biu;
            r_np     <= n_np;
            r_cnt    <= n_cnt;
            r_issue  <= n_issue;
            r_vld    <= n_vld;
            r_found  <= n_found;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_units   <= n_units;
        r_req     <= n_req;
        r_addr    <= n_addr;
        r_down    <= n_down;
        r_ev_idx  <= n_ev_idx;
        r_pick    <= n_pick;
        r_best    <= n_best;
        r_granted <= n_granted;
        r_chosen  <= n_chosen;
        r_bsize   <= n_bsize;
        r_reqsz   <= n_reqsz;
        r_left    <= n_left;
    end

    assign o_busy           = (r_state != fpba_pkg::S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_done           = r_done;
    assign o_granted        = r_granted;
    assign o_chosen_block   = r_chosen;
    assign o_block_size     = r_bsize;
    assign o_request_size   = r_reqsz;
    assign o_space_left     = r_left;
    assign o_request_number = r_cnt;

`include "fit_policy_block_allocator_assert.svh"

    `FPBA_ASSERT_NEXT(a_strobe_after_finish, r_state == fpba_pkg::S_DONE, o_done)
    `FPBA_ASSERT_NOW(a_strobe_in_idle, o_done, r_state == fpba_pkg::S_IDLE)
    `FPBA_ASSERT_NOW(a_pick_in_range, (r_state == fpba_pkg::S_DONE) && r_found, UW'(r_pick) < r_units)
    `FPBA_ASSERT_NEXT(a_pointer_wraps, (r_state == fpba_pkg::S_DONE) && r_found && (r_policy == fpba_pkg::POL_NEXT), UW'(r_np) < r_units)

endmodule
